@@ src/fixed_capacity_key_set_macros.svh @@
// assertion helpers shared by the rtl
`ifndef FIXED_CAPACITY_KEY_SET_MACROS_SVH
`define FIXED_CAPACITY_KEY_SET_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define FCKS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define FCKS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/fcks_pkg.sv @@
package fcks_pkg;

    // storage geometry
    localparam int DEPTH     = 16;
    localparam int KEY_BYTES = 8;
    localparam int KEY_W     = 64;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    // transaction field widths
    localparam int CMD_W   = 2;
    localparam int CAP_W   = 5;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESOLVE,
        ST_MOVE_WR,
        ST_DONE
    } state_t;

    // keep the low KEY_BYTES bytes up to the first zero byte, clear the rest
    function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        logic             live;
        r    = '0;
        live = 1'b1;
        for (int b = 0; b < KEY_BYTES; b++)
        begin
            if (k[8*b +: 8] == 8'h00)
            begin
                live = 1'b0;
            end
            if (live)
            begin
                r[8*b +: 8] = k[8*b +: 8];
            end
        end
        return r;
    endfunction

endpackage

@@ src/fixed_capacity_key_set.sv @@
// a transaction scans the stored keys one read at a time from the single key memory read port,
//   then resolves and loads the output register; a hit ends the scan early
// one transaction at a time: in_stall stays high until the result is in the output register,
//   and a stalled output holds the block in its done state
// a remove that moves the last entry into the freed slot adds a write-back step
// reset: asynchronous, active low; count cleared, capacity set to 16, key memory not cleared
`include "fixed_capacity_key_set_macros.svh"

module fixed_capacity_key_set
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fcks_pkg::CAP_W-1:0]      cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [fcks_pkg::CMD_W-1:0]      cmd,
    input  logic [fcks_pkg::KEY_W-1:0]      key,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            status,
    output logic                            found,
    output logic [fcks_pkg::SLOT_W-1:0]     slot,
    output logic [fcks_pkg::COUNT_W-1:0]    count
);

    localparam int ADDR_W = fcks_pkg::ADDR_W;
    localparam int CNT_W  = fcks_pkg::CNT_W;
    localparam int KEY_W  = fcks_pkg::KEY_W;

    // control registers
    fcks_pkg::state_t                 state_reg, state_next;
    logic [CNT_W-1:0]                 entry_count_reg, entry_count_next;
    logic [fcks_pkg::CAP_W-1:0]       cap_reg, cap_next;
    logic [CNT_W-1:0]                 issue_reg, issue_next;
    logic                             pend_vld_reg, pend_vld_next;
    logic                             out_valid_reg, out_valid_next;

    // payload registers
    fcks_pkg::cmd_t                   cmd_reg, cmd_next;
    logic [KEY_W-1:0]                 key_reg, key_next;
    logic [ADDR_W-1:0]                pend_idx_reg, pend_idx_next;
    logic                             hit_reg, hit_next;
    logic [ADDR_W-1:0]                pos_reg, pos_next;
    logic                             res_status_reg, res_status_next;
    logic                             out_status_reg, out_status_next;
    logic                             out_found_reg, out_found_next;
    logic [fcks_pkg::SLOT_W-1:0]      out_slot_reg, out_slot_next;
    logic [fcks_pkg::COUNT_W-1:0]     out_count_reg, out_count_next;

    // key memory
    logic [KEY_W-1:0]                 key_mem [fcks_pkg::DEPTH];
    logic [KEY_W-1:0]                 rd_data;
    logic [ADDR_W-1:0]                mem_raddr;
    logic                             mem_we;
    logic [ADDR_W-1:0]                mem_waddr;
    logic [KEY_W-1:0]                 mem_wdata;

    logic [CNT_W-1:0]                 eff_cap;
    logic [CNT_W-1:0]                 last_idx;
    logic                             out_load;

    // capacity saturates at the memory depth
    always_comb
    begin
        if (CNT_W'(cap_reg) > CNT_W'(fcks_pkg::DEPTH))
        begin
            eff_cap = CNT_W'(fcks_pkg::DEPTH);
        end
        else
        begin
            eff_cap = CNT_W'(cap_reg);
        end
    end

    assign last_idx = entry_count_reg - CNT_W'(1);

    // synchronous key memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_waddr] <= mem_wdata;
        end
        rd_data <= key_mem[mem_raddr];
    end

    // sequencer: next state, memory control and register updates
    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        cap_next         = cap_reg;
        issue_next       = issue_reg;
        pend_vld_next    = pend_vld_reg;
        out_valid_next   = out_valid_reg;
        cmd_next         = cmd_reg;
        key_next         = key_reg;
        pend_idx_next    = pend_idx_reg;
        hit_next         = hit_reg;
        pos_next         = pos_reg;
        res_status_next  = res_status_reg;
        out_status_next  = out_status_reg;
        out_found_next   = out_found_reg;
        out_slot_next    = out_slot_reg;
        out_count_next   = out_count_reg;

        mem_we    = 1'b0;
        mem_waddr = entry_count_reg[ADDR_W-1:0];
        mem_wdata = key_reg;
        mem_raddr = issue_reg[ADDR_W-1:0];
        out_load  = 1'b0;

        in_stall = (state_reg != fcks_pkg::ST_IDLE);

        // configuration write
        if (cfg_we)
        begin
            cap_next = cfg_wdata;
        end

        // result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            fcks_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next      = fcks_pkg::cmd_t'(cmd);
                    key_next      = fcks_pkg::norm_key(key);
                    issue_next    = '0;
                    pend_vld_next = 1'b0;
                    hit_next      = 1'b0;
                    pos_next      = '0;
                    state_next    = fcks_pkg::ST_SCAN;
                end
            end

            // issue one read a cycle, compare the previous read
            fcks_pkg::ST_SCAN:
            begin
                if (pend_vld_reg && (rd_data == key_reg))
                begin
                    hit_next      = 1'b1;
                    pos_next      = pend_idx_reg;
                    pend_vld_next = 1'b0;
                    state_next    = fcks_pkg::ST_RESOLVE;
                end
                else if (issue_reg < entry_count_reg)
                begin
                    issue_next    = issue_reg + CNT_W'(1);
                    pend_vld_next = 1'b1;
                    pend_idx_next = issue_reg[ADDR_W-1:0];
                end
                else
                begin
                    pend_vld_next = 1'b0;
                    state_next    = fcks_pkg::ST_RESOLVE;
                end
            end

            // apply the command
            fcks_pkg::ST_RESOLVE:
            begin
                state_next = fcks_pkg::ST_DONE;
                case (cmd_reg)
                    fcks_pkg::CMD_INSERT:
                    begin
                        if (hit_reg || (entry_count_reg >= eff_cap))
                        begin
                            res_status_next = 1'b1;
                        end
                        else
                        begin
                            mem_we           = 1'b1;
                            entry_count_next = entry_count_reg + CNT_W'(1);
                            res_status_next  = 1'b0;
                        end
                    end
                    fcks_pkg::CMD_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            res_status_next = 1'b0;
                            if (pos_reg == last_idx[ADDR_W-1:0])
                            begin
                                entry_count_next = last_idx;
                            end
                            else
                            begin
                                mem_raddr  = last_idx[ADDR_W-1:0];
                                state_next = fcks_pkg::ST_MOVE_WR;
                            end
                        end
                        else
                        begin
                            res_status_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        res_status_next = !hit_reg;
                    end
                endcase
            end

            // last entry moves into the freed slot
            fcks_pkg::ST_MOVE_WR:
            begin
                mem_we           = 1'b1;
                mem_waddr        = pos_reg;
                mem_wdata        = rd_data;
                entry_count_next = last_idx;
                state_next       = fcks_pkg::ST_DONE;
            end

            // hand the result to the output register once it is free
            fcks_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load        = 1'b1;
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_found_next  = hit_reg;
                    out_slot_next   = hit_reg ? fcks_pkg::SLOT_W'(pos_reg) : '0;
                    out_count_next  = fcks_pkg::COUNT_W'(entry_count_reg);
                    state_next      = fcks_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = fcks_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= fcks_pkg::ST_IDLE;
            entry_count_reg <= '0;
            cap_reg         <= fcks_pkg::CAP_W'(16);
            issue_reg       <= '0;
            pend_vld_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            cap_reg         <= cap_next;
            issue_reg       <= issue_next;
            pend_vld_reg    <= pend_vld_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        pend_idx_reg   <= pend_idx_next;
        hit_reg        <= hit_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_slot_reg   <= out_slot_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign found     = out_found_reg;
    assign slot      = out_slot_reg;
    assign count     = out_count_reg;

    // a memory write only adds within capacity or moves the last entry
    `FCKS_ASSERT_NOW(a_write_in_range, clk, rst_n, mem_we, (entry_count_reg < eff_cap) || (state_reg == fcks_pkg::ST_MOVE_WR), "key memory written outside capacity")

    // the count only changes when a command resolves or a move completes
    `FCKS_ASSERT_NEXT(a_count_update, clk, rst_n, (state_reg != fcks_pkg::ST_RESOLVE) && (state_reg != fcks_pkg::ST_MOVE_WR), $stable(entry_count_reg), "entry count changed outside resolve")

    // a result is loaded only when the output register is free or being drained
    `FCKS_ASSERT_NOW(a_no_overwrite, clk, rst_n, out_load, !out_valid_reg || !out_stall, "pending result overwritten")

    // an accepted transaction always starts a scan
    `FCKS_ASSERT_NEXT(a_accept_scan, clk, rst_n, in_valid && !in_stall, state_reg == fcks_pkg::ST_SCAN, "accepted transaction did not start scan")

endmodule

@@ verif/fixed_capacity_key_set_test.sv @@
`timescale 1ns / 100ps

module fixed_capacity_key_set_test;

    localparam int DEPTH     = fcks_pkg::DEPTH;
    localparam int KEY_BYTES = fcks_pkg::KEY_BYTES;
    localparam int KEY_W     = fcks_pkg::KEY_W;
    localparam int CMD_W     = fcks_pkg::CMD_W;
    localparam int CAP_W     = fcks_pkg::CAP_W;
    localparam int SLOT_W    = fcks_pkg::SLOT_W;
    localparam int COUNT_W   = fcks_pkg::COUNT_W;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int LONG_HOLD     = 300;
    // comfortably above the worst case per transaction
    localparam int SETTLE_CYCLES = 30;
    localparam int TIMEOUT_NS    = 10_000_000;
    localparam int POOL_SIZE     = 24;
    localparam int NUM_PHASES    = 6;
    localparam int MAX_CAP_CODE  = 31;

    // code 3 is not decoded and acts as a lookup
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // directed keys: short string, its alias with junk past the terminator,
    // full-length all-ones, single byte, empty string and an alias of it
    localparam logic [KEY_W-1:0] KEY_ABC       = 64'h0000_0000_0063_6261;
    localparam logic [KEY_W-1:0] KEY_ABC_ALIAS = 64'h1234_5600_0063_6261;
    localparam logic [KEY_W-1:0] KEY_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [KEY_W-1:0] KEY_ONE_BYTE  = 64'h0000_0000_0000_0001;
    localparam logic [KEY_W-1:0] KEY_EMPTY     = 64'h0;
    localparam logic [KEY_W-1:0] KEY_EMPTY_ALT = 64'hABCD_EF00_1234_5600;

    typedef struct packed {
        logic               status;
        logic               found;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] count;
    } set_result_t;

    typedef enum logic {
        ROW_OP,
        ROW_CAP
    } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [CMD_W-1:0]   op;
        logic [KEY_W-1:0]   key_val;
        logic               typed;
        set_result_t        want;
    } script_row_t;

    // per-phase capacity, transaction count and command mix
    int phase_cap   [NUM_PHASES] = '{16, 31, 5, 0, 1, 16};
    int phase_items [NUM_PHASES] = '{200, 150, 150, 80, 80, 150};
    int phase_ins   [NUM_PHASES] = '{50, 45, 30, 40, 45, 50};
    int phase_rem   [NUM_PHASES] = '{20, 25, 40, 30, 25, 20};

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CAP_W-1:0]    cfg_wdata = '0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [CMD_W-1:0]    cmd       = '0;
    logic [KEY_W-1:0]    key       = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                status;
    logic                found;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  count;

    // typed expectation travelling with the offered transaction
    logic                op_typed = 1'b0;
    set_result_t         op_want  = '0;

    // shadow of the set
    logic [KEY_W-1:0]    held_keys [DEPTH];
    int                  held_count = 0;
    int                  cap_reg    = 16;

    set_result_t         results_due [$];
    script_row_t         script [$];
    logic [KEY_W-1:0]    pool_base [POOL_SIZE];
    int                  pool_nul  [POOL_SIZE];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit long_hold_req = 1'b0;
    int hold_left     = 0;

    int mismatches  = 0;
    int accepted    = 0;
    int hits        = 0;
    int rejects     = 0;
    int peak_count  = 0;
    int cap_writes  = 0;

    fixed_capacity_key_set u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .key       (key),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .found     (found),
        .slot      (slot),
        .count     (count)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // drop everything past the first zero byte
    function automatic logic [KEY_W-1:0] clip_key(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] k;
        int               b;
        k = '0;
        for (b = 0; b < KEY_BYTES; b++)
        begin
            if (raw[8*b +: 8] == 8'h00)
                break;
            k[8*b +: 8] = raw[8*b +: 8];
        end
        return k;
    endfunction

    // linear search over filled slots, then apply the command to the shadow set
    function automatic set_result_t apply_op(input logic [CMD_W-1:0] op,
                                             input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] k;
        int               n;
        int               pos;
        int               limit;
        int               i;
        logic             hit;
        set_result_t      r;
        k     = clip_key(raw);
        n     = held_count;
        pos   = 0;
        hit   = 1'b0;
        limit = (cap_reg > DEPTH) ? DEPTH : cap_reg;
        for (i = 0; i < n; i++)
        begin
            if (!hit && held_keys[i] == k)
            begin
                hit = 1'b1;
                pos = i;
            end
        end
        r.status = 1'b1;
        case (op)
            fcks_pkg::CMD_INSERT:
            begin
                if (!hit && n < limit)
                begin
                    held_keys[n] = k;
                    n++;
                    r.status = 1'b0;
                end
            end
            fcks_pkg::CMD_REMOVE:
            begin
                if (hit)
                begin
                    held_keys[pos] = held_keys[n-1];
                    n--;
                    r.status = 1'b0;
                end
            end
            default:
            begin
                r.status = !hit;
            end
        endcase
        held_count = n;
        r.found    = hit;
        r.slot     = hit ? SLOT_W'(pos) : '0;
        r.count    = COUNT_W'(n);
        return r;
    endfunction

    // mostly keys from a small pool so hits are common, some fully random
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        int               idx;
        int               b;
        if ($urandom_range(0, 99) < 10)
            return {$urandom, $urandom};
        idx = $urandom_range(0, POOL_SIZE-1);
        k   = pool_base[idx];
        // junk above the terminator must not matter
        if (pool_nul[idx] < KEY_BYTES && $urandom_range(0, 1) == 1)
        begin
            for (b = pool_nul[idx] + 1; b < KEY_BYTES; b++)
                k[8*b +: 8] = 8'($urandom);
        end
        return k;
    endfunction

    task automatic add_op(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] k,
                          input logic typed, input set_result_t want);
        script_row_t row;
        row.kind    = ROW_OP;
        row.op      = op;
        row.key_val = k;
        row.typed   = typed;
        row.want    = want;
        script.push_back(row);
    endtask

    task automatic add_cap(input int v);
        script_row_t row;
        row.kind    = ROW_CAP;
        row.op      = fcks_pkg::CMD_LOOKUP;
        row.key_val = KEY_W'(v);
        row.typed   = 1'b0;
        row.want    = '0;
        script.push_back(row);
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0:
            begin
                send_idle_pct = 15;
                recv_idle_pct = 88;
            end
            1:
            begin
                send_idle_pct = 88;
                recv_idle_pct = 15;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // offer one transaction, return once it has been taken
    task automatic offer_op(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] k,
                            input logic typed, input set_result_t want);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        key      <= k;
        op_typed <= typed;
        op_want  <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // stop offering and wait until the block has nothing left to deliver
    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_capacity(input int v);
        quiesce();
        cfg_we    <= 1'b1;
        cfg_wdata <= v[CAP_W-1:0];
        cap_reg    = v & MAX_CAP_CODE;
        cap_writes++;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // receiver: random stalls, or a long hold when one is requested
    always @(negedge clk)
    begin
        if (long_hold_req)
        begin
            hold_left     = LONG_HOLD;
            long_hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // accepted transaction: update the shadow set and queue the expected result
    always @(posedge clk)
    begin : take_command
        set_result_t predicted;
        if (rst_n && in_valid && !in_stall)
        begin
            predicted = apply_op(cmd, key);
            results_due.push_back(op_typed ? op_want : predicted);
            accepted++;
            if (predicted.found)
                hits++;
            if (predicted.status)
                rejects++;
            if (held_count > peak_count)
                peak_count = held_count;
        end
    end

    // delivered result: compare against the oldest expectation
    always @(posedge clk)
    begin : check_response
        set_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (results_due.size() == 0)
            begin
                $error("unexpected result: status %0d found %0d slot %0d count %0d",
                       status, found, slot, count);
                mismatches++;
            end
            else
            begin
                want = results_due.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatches++;
                end
                if (found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, found);
                    mismatches++;
                end
                if (slot !== want.slot)
                begin
                    $error("slot: expected %0d, got %0d", want.slot, slot);
                    mismatches++;
                end
                if (count !== want.count)
                begin
                    $error("count: expected %0d, got %0d", want.count, count);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("FAIL fixed_capacity_key_set");
        $finish;
    end

    initial
    begin
        int               i;
        int               b;
        int               ph;
        int               n;
        int               r;
        logic [CMD_W-1:0] op;
        script_row_t      row;

        // key pool: nonzero bytes up to a random terminator position
        for (i = 0; i < POOL_SIZE; i++)
        begin
            pool_nul[i] = $urandom_range(0, KEY_BYTES);
            for (b = 0; b < KEY_BYTES; b++)
                pool_base[i][8*b +: 8] = (b < pool_nul[i]) ? 8'($urandom_range(1, 255)) : 8'h00;
        end

        // directed script, starting from an empty set at capacity 16
        add_op(fcks_pkg::CMD_LOOKUP, KEY_ABC,       1'b1, {1'b1, 1'b0, 4'd0, 5'd0});
        add_op(fcks_pkg::CMD_REMOVE, KEY_ABC,       1'b1, {1'b1, 1'b0, 4'd0, 5'd0});
        add_op(fcks_pkg::CMD_INSERT, KEY_ABC,       1'b1, {1'b0, 1'b0, 4'd0, 5'd1});
        add_op(fcks_pkg::CMD_INSERT, KEY_ABC_ALIAS, 1'b1, {1'b1, 1'b1, 4'd0, 5'd1});
        add_op(fcks_pkg::CMD_LOOKUP, KEY_ABC_ALIAS, 1'b1, {1'b0, 1'b1, 4'd0, 5'd1});
        add_op(fcks_pkg::CMD_INSERT, KEY_ONES,      1'b1, {1'b0, 1'b0, 4'd0, 5'd2});
        add_op(fcks_pkg::CMD_INSERT, KEY_ONE_BYTE,  1'b0, '0);
        add_op(fcks_pkg::CMD_INSERT, KEY_EMPTY,     1'b0, '0);
        add_op(CMD_UNUSED,           KEY_ONES,      1'b1, {1'b0, 1'b1, 4'd1, 5'd4});
        // removing slot 0 pulls the last entry down into it
        add_op(fcks_pkg::CMD_REMOVE, KEY_ABC,       1'b1, {1'b0, 1'b1, 4'd0, 5'd3});
        add_op(fcks_pkg::CMD_LOOKUP, KEY_EMPTY_ALT, 1'b0, '0);
        // removal from the last filled slot
        add_op(fcks_pkg::CMD_REMOVE, KEY_ONE_BYTE,  1'b1, {1'b0, 1'b1, 4'd2, 5'd2});
        add_op(fcks_pkg::CMD_LOOKUP, KEY_ONE_BYTE,  1'b1, {1'b1, 1'b0, 4'd0, 5'd2});
        // capacity below the held count keeps the keys
        add_cap(1);
        add_op(fcks_pkg::CMD_INSERT, KEY_ABC,       1'b1, {1'b1, 1'b0, 4'd0, 5'd2});
        add_op(fcks_pkg::CMD_INSERT, KEY_EMPTY,     1'b1, {1'b1, 1'b1, 4'd0, 5'd2});
        add_cap(3);
        add_op(fcks_pkg::CMD_INSERT, KEY_ABC,       1'b1, {1'b0, 1'b0, 4'd0, 5'd3});
        add_op(fcks_pkg::CMD_INSERT, KEY_ONE_BYTE,  1'b1, {1'b1, 1'b0, 4'd0, 5'd3});
        add_cap(0);
        add_op(fcks_pkg::CMD_REMOVE, KEY_ONES,      1'b0, '0);
        add_op(fcks_pkg::CMD_LOOKUP, KEY_ABC,       1'b0, '0);
        add_op(fcks_pkg::CMD_INSERT, KEY_ONES,      1'b1, {1'b1, 1'b0, 4'd0, 5'd2});
        // codes above DEPTH saturate
        add_cap(MAX_CAP_CODE);
        add_op(fcks_pkg::CMD_INSERT, KEY_ONES,      1'b1, {1'b0, 1'b0, 4'd0, 5'd3});
        add_op(fcks_pkg::CMD_REMOVE, KEY_ONES,      1'b1, {1'b0, 1'b1, 4'd2, 5'd2});

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_idle(0);
        for (i = 0; i < script.size(); i++)
        begin
            row = script[i];
            if (row.kind == ROW_CAP)
                set_capacity(int'(row.key_val));
            else
                offer_op(row.op, row.key_val, row.typed, row.want);
        end

        // random phases, each at its own capacity and idling mode
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            set_capacity(phase_cap[ph]);
            set_idle(ph % 3);
            for (n = 0; n < phase_items[ph]; n++)
            begin
                // output held back while input keeps coming
                if (ph == 0 && n == 40)
                    long_hold_req = 1'b1;
                r = $urandom_range(0, 99);
                if (r < phase_ins[ph])
                    op = fcks_pkg::CMD_INSERT;
                else if (r < phase_ins[ph] + phase_rem[ph])
                    op = fcks_pkg::CMD_REMOVE;
                else if (r < 95)
                    op = fcks_pkg::CMD_LOOKUP;
                else
                    op = CMD_UNUSED;
                offer_op(op, pick_key(), 1'b0, '0);
            end
        end
        quiesce();

        $display("run covered %0d transactions over %0d capacity writes, peak occupancy %0d",
                 accepted, cap_writes, peak_count);
        $display("%0d hits, %0d rejected commands, %0d field mismatches",
                 hits, rejects, mismatches);
        if (mismatches == 0)
            $display("PASS fixed_capacity_key_set");
        else
            $display("FAIL fixed_capacity_key_set");
        $finish;
    end

endmodule
